// ===== rtl/core/rrqs_pkg.sv =====
// Shared types and constants for the round-robin quantum scheduler.
`timescale 1ns / 1ps

package rrqs_pkg;

  localparam int unsigned SlotsDef   = 16;
  localparam int unsigned TidW       = 4;
  localparam int unsigned QuantumW   = 8;
  localparam logic [QuantumW-1:0] QuantumRst = 8'd20;

  // APB register map
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;
  localparam logic [PaddrW-1:0] AddrQuantum = 3'd0;

  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_EXIT    = 2'd2,
    KIND_SETPRIO = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_CREATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_SWITCHED = 3'd3,
    ST_HALTED   = 3'd4
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  typedef struct packed {
    kind_e kind;
    logic  priority_req;
  } in_req_t;

  typedef struct packed {
    status_e         status;
    logic [TidW-1:0] thread_id;
    logic [TidW-1:0] running_thread;
    logic            running_priority;
  } out_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

// ===== rtl/core/round_robin_quantum_scheduler.sv =====
// Top level of the round-robin quantum scheduler with its APB register.
`timescale 1ns / 1ps

// Round-robin time-slice scheduler over a table of SLOTS thread slots.
// Requests come in on in_req_i (kind, priority_req) with in_valid_i/in_ready_o;
// each request gives exactly one response on out_rsp_o with out_valid_o/out_ready_i.
// kind: create takes the lowest free slot and queues it, tick counts down the
// running slice and rotates through the ready queue, exit frees the running slot,
// set-priority stores the running slot's priority (reported only).
// Timing: a request is taken in the idle state; the exec state then commits it
// and loads the response register, which drives out_valid_o. No new request is
// accepted until the two-state controller (accept, then commit after the
// registered queue-head read and free-slot search) has committed the last one.
// Stalls: the response register is held while out_ready_i is low; a further
// request is still accepted, but its commit waits until the register drains.
// Reset (rst_ni, async, active low): slot 0 in use and running, queue empty,
// slice counter and slice length register at 20, not halted. After an exit with an
// empty queue the block is halted and answers every request with status 4.
// Register: slice length at byte address 0 (8 bits); write only while idle.

module round_robin_quantum_scheduler #(
  parameter int unsigned SLOTS = rrqs_pkg::SlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rrqs_pkg::in_req_t             in_req_i,
  // response channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rrqs_pkg::out_rsp_t            out_rsp_o,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrqs_pkg::PaddrW-1:0]   paddr,
  input  logic [rrqs_pkg::PdataW-1:0]   pwdata,
  output logic [rrqs_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);
  import rrqs_pkg::*;

  dp_cmd_t             cmd;
  logic [QuantumW-1:0] quantum_q;

  // Slice length register; a write with quantum 0 acts as 1 in the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QuantumRst;
    end else if (psel && penable && pwrite && pready && (paddr == AddrQuantum)) begin
      quantum_q <= pwdata[QuantumW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == AddrQuantum) ? {{(PdataW-QuantumW){1'b0}}, quantum_q} : '0;

  rrqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  rrqs_datapath #(
    .Slots (SLOTS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .req_i     (in_req_i),
    .quantum_i (quantum_q),
    .rsp_o     (out_rsp_o)
  );

endmodule

// ===== rtl/core/rrqs_ctrl.sv =====
// Controller FSM for the scheduler: request handshakes and commit sequencing.
`timescale 1ns / 1ps

module rrqs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rrqs_pkg::dp_cmd_t cmd_o
);
  import rrqs_pkg::*;

  fsm_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    in_ready_o    = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = FSM_IDLE;
        end
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/rrqs_datapath.sv =====
// Scheduler datapath: slot table, ready queue memory, slice counter, result register.
`timescale 1ns / 1ps

module rrqs_datapath #(
  parameter int unsigned Slots = rrqs_pkg::SlotsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rrqs_pkg::dp_cmd_t                cmd_i,
  input  rrqs_pkg::in_req_t                req_i,
  input  logic [rrqs_pkg::QuantumW-1:0]    quantum_i,
  output rrqs_pkg::out_rsp_t               rsp_o
);
  import rrqs_pkg::*;

  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned CntW  = $clog2(Slots + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(Slots - 1);

  // state
  logic [Slots-1:0]    in_use_q, in_use_d;
  logic [Slots-1:0]    prio_q, prio_d;
  logic [SlotW-1:0]    head_q, head_d;
  logic [SlotW-1:0]    tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [SlotW-1:0]    cur_q, cur_d;
  logic [QuantumW-1:0] ticks_q, ticks_d;
  logic                halted_q, halted_d;

  logic [SlotW-1:0]    fifo_mem [Slots];
  logic [SlotW-1:0]    head_data_q;
  logic                push;
  logic [SlotW-1:0]    push_data;

  in_req_t             req_q;
  out_rsp_t            rsp_q, rsp_d;

  // lowest free slot, registered
  logic [SlotW-1:0]    free_idx, free_idx_q;
  logic                free_found, free_found_q;

  logic [SlotW-1:0]    tid_slot;

  function automatic logic [TidW-1:0] to_tid(input logic [SlotW-1:0] s);
    logic [TidW+SlotW-1:0] ext;
    ext = {{TidW{1'b0}}, s};
    return ext[TidW-1:0];
  endfunction

  function automatic logic [SlotW-1:0] ring_inc(input logic [SlotW-1:0] p);
    return (p == LastSlot) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx   = SlotW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q   <= free_idx;
    free_found_q <= free_found;
    head_data_q  <= fifo_mem[head_q];
    if (push) begin
      fifo_mem[tail_q] <= push_data;
    end
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  always_comb begin
    in_use_d  = in_use_q;
    prio_d    = prio_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    cur_d     = cur_q;
    ticks_d   = ticks_q;
    halted_d  = halted_q;
    push      = 1'b0;
    push_data = cur_q;
    tid_slot  = '0;
    rsp_d.status = ST_NONE;

    if (halted_q) begin
      rsp_d.status = ST_HALTED;
    end else begin
      unique case (req_q.kind)
        KIND_CREATE: begin
          if (free_found_q) begin
            in_use_d[free_idx_q] = 1'b1;
            prio_d[free_idx_q]   = req_q.priority_req;
            push                 = 1'b1;
            push_data            = free_idx_q;
            tail_d               = ring_inc(tail_q);
            count_d              = count_q + 1'b1;
            rsp_d.status         = ST_CREATED;
            tid_slot             = free_idx_q;
          end else begin
            rsp_d.status = ST_FULL;
          end
        end
        KIND_TICK: begin
          if (ticks_q <= QuantumW'(1)) begin
            if (count_q != '0) begin
              // rotate: head becomes running, old running to tail
              head_d       = ring_inc(head_q);
              push         = 1'b1;
              push_data    = cur_q;
              tail_d       = ring_inc(tail_q);
              cur_d        = head_data_q;
              rsp_d.status = ST_SWITCHED;
              tid_slot     = head_data_q;
            end
            ticks_d = quantum_i;
          end else begin
            ticks_d = ticks_q - 1'b1;
          end
        end
        KIND_EXIT: begin
          in_use_d[cur_q] = 1'b0;
          if (count_q != '0) begin
            head_d       = ring_inc(head_q);
            count_d      = count_q - 1'b1;
            cur_d        = head_data_q;
            ticks_d      = quantum_i;
            rsp_d.status = ST_SWITCHED;
            tid_slot     = head_data_q;
          end else begin
            halted_d     = 1'b1;
            rsp_d.status = ST_HALTED;
          end
        end
        KIND_SETPRIO: begin
          prio_d[cur_q] = req_q.priority_req;
        end
      endcase
    end

    if (!cmd_i.commit) begin
      push = 1'b0;
    end

    rsp_d.thread_id        = to_tid(tid_slot);
    rsp_d.running_thread   = to_tid(cur_d);
    rsp_d.running_priority = prio_d[cur_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= Slots'(1);
      prio_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      cur_q    <= '0;
      ticks_q  <= QuantumRst;
      halted_q <= 1'b0;
    end else if (cmd_i.commit) begin
      in_use_q <= in_use_d;
      prio_q   <= prio_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      cur_q    <= cur_d;
      ticks_q  <= ticks_d;
      halted_q <= halted_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== sim/scheduler_checker.sv =====
// Request/response checker with a behavioural predictor of the quantum scheduler.
`timescale 1ns / 1ps

module scheduler_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  rrqs_pkg::in_req_t             in_req_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  rrqs_pkg::out_rsp_t            out_rsp_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [rrqs_pkg::PaddrW-1:0]   paddr_i,
  input  logic [rrqs_pkg::PdataW-1:0]   pwdata_i,
  output int unsigned                   pending_o,
  output int unsigned                   errors_o
);
  import rrqs_pkg::*;

  localparam int unsigned Slots = SlotsDef;

  // predictor state
  logic [QuantumW-1:0] quantum;
  logic [QuantumW-1:0] slice_left;
  logic                slot_busy [Slots];
  logic                slot_prio [Slots];
  logic [TidW-1:0]     ready_q [$];
  logic [TidW-1:0]     running;
  logic                halted;

  out_rsp_t            expected_rsp_q [$];
  int unsigned         errors = 0;

  task automatic reset_model();
    int i;
    for (i = 0; i < Slots; i++) begin
      slot_busy[i] = 1'b0;
      slot_prio[i] = 1'b0;
    end
    slot_busy[0] = 1'b1;
    ready_q.delete();
    running    = '0;
    quantum    = QuantumRst;
    slice_left = QuantumRst;
    halted     = 1'b0;
  endtask

  task automatic predict(input in_req_t req, output out_rsp_t rsp);
    int              i;
    int              free_slot;
    status_e         st;
    logic [TidW-1:0] tid;
    free_slot = -1;
    st        = ST_NONE;
    tid       = '0;
    if (halted) begin
      st = ST_HALTED;
    end else begin
      case (req.kind)
        KIND_CREATE: begin
          // lowest free slot wins
          for (i = Slots - 1; i >= 0; i--)
            if (!slot_busy[i]) free_slot = i;
          if (free_slot < 0) begin
            st = ST_FULL;
          end else begin
            slot_busy[free_slot] = 1'b1;
            slot_prio[free_slot] = req.priority_req;
            ready_q.push_back(free_slot[TidW-1:0]);
            st  = ST_CREATED;
            tid = free_slot[TidW-1:0];
          end
        end
        KIND_TICK: begin
          // a slice counter of 0 or 1 ends the slice
          if (slice_left <= 1) begin
            if (ready_q.size() != 0) begin
              tid = ready_q.pop_front();
              ready_q.push_back(running);
              running = tid;
              st      = ST_SWITCHED;
            end
            slice_left = quantum;
          end else begin
            slice_left = slice_left - 1'b1;
          end
        end
        KIND_EXIT: begin
          slot_busy[running] = 1'b0;
          if (ready_q.size() != 0) begin
            tid        = ready_q.pop_front();
            running    = tid;
            slice_left = quantum;
            st         = ST_SWITCHED;
          end else begin
            halted = 1'b1;
            st     = ST_HALTED;
          end
        end
        default: begin
          slot_prio[running] = req.priority_req;
        end
      endcase
    end
    rsp.status           = st;
    rsp.thread_id        = tid;
    rsp.running_thread   = running;
    rsp.running_priority = slot_prio[running];
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t want;
    out_rsp_t got;
    if (!rst_ni) begin
      reset_model();
      expected_rsp_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == AddrQuantum)
        quantum = pwdata_i[QuantumW-1:0];
      if (in_valid_i && in_ready_i) begin
        predict(in_req_i, want);
        expected_rsp_q.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        got = out_rsp_i;
        if (expected_rsp_q.size() == 0) begin
          $display("%0t ns: response with nothing expected, got status %0d thread %0d %s",
                   $time, got.status, got.thread_id, "");
          $display("%0t ns:   running %0d prio %0d", $time, got.running_thread,
                   got.running_priority);
          errors++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", 8'(want.status), 8'(got.status));
          check_field("thread_id", 8'(want.thread_id), 8'(got.thread_id));
          check_field("running_thread", 8'(want.running_thread), 8'(got.running_thread));
          check_field("running_priority", 8'(want.running_priority),
                      8'(got.running_priority));
        end
      end
    end
    pending_o <= expected_rsp_q.size();
    errors_o  <= errors;
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the scheduler testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import rrqs_pkg::*;

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  in_req_t             in_req    = '0;
  logic                out_ready = 1'b0;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PaddrW-1:0]   paddr     = '0;
  logic [PdataW-1:0]   pwdata    = '0;

  logic                in_ready;
  logic                out_valid;
  out_rsp_t            out_rsp;
  logic [PdataW-1:0]   prdata;
  logic                pready;
  int unsigned         pending;
  int unsigned         errors;

  // idling knobs, percent of cycles
  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  // long receiver hold-off, picked up and counted down by the receiver process
  int                  hold_request  = 0;
  int                  hold_left     = 0;
  // live thread count, tracked only so that random exits never empty the
  // ready queue before the final halting sequence
  int                  live_threads  = 1;

  round_robin_quantum_scheduler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  scheduler_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run (~1.5k requests plus hold-offs).
  initial begin
    #(64'd2_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offer one request and wait for it to be taken. Valid is only dropped when
  // a gap is drawn, so back-to-back requests keep it high without a glitch.
  task automatic push_request(input kind_e k, input logic prio);
    in_req_t req;
    req.kind         = k;
    req.priority_req = prio;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk_i); while (!in_ready);
    if (k == KIND_CREATE && live_threads < SlotsDef) live_threads++;
    else if (k == KIND_EXIT && live_threads > 0) live_threads--;
  endtask

  // Weighted random request; exits turn into ticks when only one thread lives.
  task automatic random_request(input int create_w, input int exit_w);
    int    roll;
    kind_e k;
    roll = $urandom_range(0, 99);
    if (roll < create_w) k = KIND_CREATE;
    else if (roll < create_w + 35) k = KIND_TICK;
    else if (roll < create_w + 35 + exit_w) k = (live_threads > 1) ? KIND_EXIT : KIND_TICK;
    else k = KIND_SETPRIO;
    push_request(k, 1'($urandom_range(0, 1)));
  endtask

  // Stop offering and let every outstanding response drain, plus a little slack.
  task automatic go_quiet();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Two-phase APB write of the quantum; upper data bits are random junk.
  task automatic apb_write_quantum(input logic [QuantumW-1:0] value);
    logic [PdataW-1:0] word;
    word              = $urandom();
    word[QuantumW-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrQuantum;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int          ph;
    int          n;
    int          i;
    logic [QuantumW-1:0] q;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset quantum of 20, priority both ways, create, exit with a
    // non-empty queue, slot reuse after exit, table full, plain tick.
    push_request(KIND_SETPRIO, 1'b1);
    push_request(KIND_TICK, 1'b0);
    push_request(KIND_CREATE, 1'b0);
    push_request(KIND_CREATE, 1'b1);
    push_request(KIND_EXIT, 1'b0);
    push_request(KIND_CREATE, 1'b1);
    push_request(KIND_SETPRIO, 1'b0);
    for (i = 0; i < 13; i++) push_request(KIND_CREATE, 1'(i));
    push_request(KIND_CREATE, 1'b1);
    push_request(KIND_TICK, 1'b1);

    // Random phases: each with its own quantum and one of four idling patterns.
    // Within a phase the mix swings between filling the table and draining
    // it, so full, empty-queue ticks and rotations all get exercised.
    for (ph = 0; ph < 8; ph++) begin
      go_quiet();
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 56; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      case (ph)
        0:       q = QuantumRst;
        1:       q = 8'd1;
        2:       q = 8'd255;
        3:       q = 8'd2;
        4:       q = 8'd0;   // behaves like a quantum of one
        5:       q = 8'd3;
        6:       q = QuantumW'($urandom_range(1, 6));
        default: q = QuantumW'($urandom_range(1, 255));
      endcase
      if (ph != 0) apb_write_quantum(q);
      for (n = 0; n < 172; n++) begin
        // long receiver hold-off while requests keep coming: fills the block
        if (ph == 0 && n == 60) hold_request = 80;
        // sender pauses until every outstanding response is back
        if (ph == 1 && n == 90) begin
          in_valid <= 1'b0;
          do @(posedge clk_i); while (pending != 0);
        end
        if ((n / 48) % 2 == 0) random_request(45, 6);
        else random_request(6, 40);
      end
    end

    // Wind down: exit every thread, the last exit halts the scheduler, then
    // every kind of request must be answered as halted.
    go_quiet();
    send_idle_pct = 20;
    stall_pct     = 20;
    while (live_threads > 1) push_request(KIND_EXIT, 1'($urandom_range(0, 1)));
    push_request(KIND_EXIT, 1'b0);
    push_request(KIND_CREATE, 1'b1);
    push_request(KIND_TICK, 1'b0);
    push_request(KIND_EXIT, 1'b1);
    push_request(KIND_SETPRIO, 1'b1);
    push_request(KIND_CREATE, 1'b0);

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
